### rtl/srxl_pkg.sv
// ----------------------------------------------------------------------------
// srxl_pkg - shared types and constants of the SRXL2 channel frame parser
// Frame constants, parser state codes, result record and the CRC byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package srxl_pkg;

  // Frame framing bytes
  localparam logic [7:0] START1_BYTE = 8'hA6;
  localparam logic [7:0] START2_BYTE = 8'hCD;
  localparam logic [7:0] CMD_CHANNEL = 8'h00;
  localparam logic [7:0] MIN_LENGTH  = 8'd14;

  // CRC-16-CCITT, MSB first
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Width of the remaining channel count: (255 - 14) / 2 fits in 7 bits
  localparam int CHAN_W = 7;

  // Output beat: first_value, second_value, captured_count, zero pad
  localparam int TDATA_W = 40;

  // Configuration register indexes
  localparam logic REG_AUX_CHANNEL = 1'b0;

  // Parser states, one-hot
  typedef enum logic [15:0] {
    ST_START1  = 16'b0000_0000_0000_0001,
    ST_START2  = 16'b0000_0000_0000_0010,
    ST_LENGTH  = 16'b0000_0000_0000_0100,
    ST_COMMAND = 16'b0000_0000_0000_1000,
    ST_REPLYID = 16'b0000_0000_0001_0000,
    ST_RSSI    = 16'b0000_0000_0010_0000,
    ST_LOSS1   = 16'b0000_0000_0100_0000,
    ST_LOSS2   = 16'b0000_0000_1000_0000,
    ST_MASK1   = 16'b0000_0001_0000_0000,
    ST_MASK2   = 16'b0000_0010_0000_0000,
    ST_MASK3   = 16'b0000_0100_0000_0000,
    ST_MASK4   = 16'b0000_1000_0000_0000,
    ST_PAY1    = 16'b0001_0000_0000_0000,
    ST_PAY2    = 16'b0010_0000_0000_0000,
    ST_CRC1    = 16'b0100_0000_0000_0000,
    ST_CRC2    = 16'b1000_0000_0000_0000
  } parse_state_t;

  // One finished frame result
  typedef struct packed {
    logic [1:0]  captured_count;
    logic [15:0] second_value;
    logic [15:0] first_value;
  } frame_res_t;

  // Result hand-off from parser to output stage
  typedef struct packed {
    logic       push;
    frame_res_t res;
  } res_push_t;

  // One byte through the CRC, eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/srxl_cfg_regs.sv
// ----------------------------------------------------------------------------
// srxl_cfg_regs - APB configuration register
// Holds the auxiliary channel number; one 32-bit register at offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module srxl_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [4:0]       aux_channel
);
  import srxl_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      aux_channel <= 5'd1;
    end else if (wr_en && (paddr[2] == REG_AUX_CHANNEL)) begin
      aux_channel <= pwdata[4:0];
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_AUX_CHANNEL) begin
      prdata = {27'd0, aux_channel};
    end
  end

endmodule

`default_nettype wire

### rtl/srxl_parser.sv
// ----------------------------------------------------------------------------
// srxl_parser - frame state machine, CRC and channel capture
// Consumes one byte per accepted beat and flags a result at the CRC check.
// ----------------------------------------------------------------------------
`default_nettype none

module srxl_parser #(
  parameter int MAX_KEPT = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  input  wire logic [4:0] aux_channel,
  output srxl_pkg::res_push_t result
);
  import srxl_pkg::*;

  localparam int KW = $clog2(MAX_KEPT + 1);

  // State registers
  parse_state_t       state, state_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [CHAN_W-1:0]  channels_left, channels_left_next;
  logic [31:0]        remaining_mask, remaining_mask_next;
  logic [31:0]        wanted_mask, wanted_mask_next;
  logic [7:0]         word_buffer, word_buffer_next;
  logic [KW-1:0]      kept_count, kept_count_next;
  logic [15:0]        kept_words [MAX_KEPT];

  // Working signals
  logic [7:0]         len_diff;
  logic [31:0]        full_mask;
  logic [31:0]        low_bit;
  logic [15:0]        pay_word;
  logic [15:0]        rx_crc;
  logic [15:0]        crc_seed;
  logic               keep;
  logic               hit;
  logic [15:0]        second_word;

  assign len_diff  = rx_byte - MIN_LENGTH;
  assign full_mask = {rx_byte, remaining_mask[23:0]};
  assign pay_word  = {rx_byte, word_buffer};
  assign rx_crc    = {word_buffer, rx_byte};
  // Lowest unused mask bit picks the channel of this word
  assign low_bit   = remaining_mask & (~remaining_mask + 32'd1);
  assign crc_seed  = (state == ST_START1 && rx_byte == START1_BYTE) ? 16'd0 : running_crc;

  // Next-state logic
  always_comb begin
    state_next          = state;
    channels_left_next  = channels_left;
    remaining_mask_next = remaining_mask;
    wanted_mask_next    = wanted_mask;
    word_buffer_next    = word_buffer;
    kept_count_next     = kept_count;
    running_crc_next    = crc16_byte(crc_seed, rx_byte);
    keep                = 1'b0;
    hit                 = 1'b0;
    case (state)
      ST_START1: begin
        if (rx_byte == START1_BYTE) state_next = ST_START2;
      end
      ST_START2: begin
        state_next = (rx_byte == START2_BYTE) ? ST_LENGTH : ST_START1;
      end
      ST_LENGTH: begin
        channels_left_next = (rx_byte >= MIN_LENGTH) ? len_diff[7:1] : '0;
        state_next         = ST_COMMAND;
      end
      ST_COMMAND: begin
        if (rx_byte == CMD_CHANNEL) begin
          state_next          = ST_REPLYID;
          kept_count_next     = '0;
          remaining_mask_next = '0;
          word_buffer_next    = '0;
        end else begin
          state_next = ST_START1;
        end
      end
      ST_REPLYID: state_next = ST_RSSI;
      ST_RSSI:    state_next = ST_LOSS1;
      ST_LOSS1:   state_next = ST_LOSS2;
      ST_LOSS2: begin
        state_next = (channels_left == '0) ? ST_CRC1 : ST_MASK1;
      end
      ST_MASK1: begin
        remaining_mask_next = {24'd0, rx_byte};
        state_next          = ST_MASK2;
      end
      ST_MASK2: begin
        remaining_mask_next[15:8] = rx_byte;
        state_next                = ST_MASK3;
      end
      ST_MASK3: begin
        remaining_mask_next[23:16] = rx_byte;
        state_next                 = ST_MASK4;
      end
      ST_MASK4: begin
        remaining_mask_next = full_mask;
        wanted_mask_next    = full_mask & (32'd1 | (32'd1 << aux_channel));
        state_next          = ST_PAY1;
      end
      ST_PAY1: begin
        word_buffer_next = rx_byte;
        state_next       = ST_PAY2;
      end
      ST_PAY2: begin
        // Masks stay unshifted: the used bit is simply cleared
        keep                = ((low_bit & wanted_mask) != '0) &&
                              (kept_count < KW'(MAX_KEPT));
        remaining_mask_next = remaining_mask & ~low_bit;
        if (keep) kept_count_next = kept_count + KW'(1);
        channels_left_next  = channels_left - CHAN_W'(1);
        state_next          = (channels_left_next != '0) ? ST_PAY1 : ST_CRC1;
      end
      ST_CRC1: begin
        running_crc_next = running_crc;
        word_buffer_next = rx_byte;
        state_next       = ST_CRC2;
      end
      ST_CRC2: begin
        running_crc_next = running_crc;
        hit              = (rx_crc == running_crc) && (kept_count != '0);
        state_next       = ST_START1;
      end
      default: begin
        state_next = ST_START1;
      end
    endcase
  end

  // State update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_START1;
      running_crc    <= '0;
      channels_left  <= '0;
      remaining_mask <= '0;
      wanted_mask    <= '0;
      word_buffer    <= '0;
      kept_count     <= '0;
    end else if (accept) begin
      state          <= state_next;
      running_crc    <= running_crc_next;
      channels_left  <= channels_left_next;
      remaining_mask <= remaining_mask_next;
      wanted_mask    <= wanted_mask_next;
      word_buffer    <= word_buffer_next;
      kept_count     <= kept_count_next;
    end
  end

  // Captured channel words
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      if (accept && keep && (kept_count == KW'(i))) begin
        kept_words[i] <= pay_word;
      end
    end
  end

  // Second word exists only with room for two
  generate
    if (MAX_KEPT >= 2) begin : g_second
      assign second_word = (kept_count >= KW'(2)) ? kept_words[1] : 16'd0;
    end else begin : g_no_second
      assign second_word = 16'd0;
    end
  endgenerate

  assign result.push               = accept && hit;
  assign result.res.first_value    = kept_words[0];
  assign result.res.second_value   = second_word;
  assign result.res.captured_count = 2'(kept_count);

endmodule

`default_nettype wire

### rtl/srxl_out_skid.sv
// ----------------------------------------------------------------------------
// srxl_out_skid - result register with skid stage
// Holds results for the output channel; ready upstream is a registered flag.
// ----------------------------------------------------------------------------
`default_nettype none

module srxl_out_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire srxl_pkg::res_push_t result,
  output logic                    ready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output srxl_pkg::frame_res_t    m_res
);
  import srxl_pkg::*;

  logic       out_valid;
  logic       skid_valid;
  frame_res_t out_res;
  frame_res_t skid_res;
  logic       pop;

  assign pop      = out_valid && m_tready;
  assign ready    = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_res    = out_res;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || result.push;
      skid_valid <= skid_valid && result.push;
    end else if (result.push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res  <= skid_res;
        skid_res <= result.res;
      end else begin
        out_res <= result.res;
      end
    end else if (result.push) begin
      skid_res <= result.res;
    end
  end

endmodule

`default_nettype wire

### rtl/srxl2_channel_frame_parser.sv
// ----------------------------------------------------------------------------
// srxl2_channel_frame_parser - SRXL2 channel data frame parser
// Pulls channel 0 and one auxiliary channel out of CRC-checked frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one received serial byte per beat in s_tdata[7:0].
//   m_* channel: one beat per good frame that captured a channel word.
//   APB port: register 0 (offset 0) is aux_channel, bits [4:0], reset 1.
// Timing:
//   One byte is taken every cycle while s_tready is high. The frame state
//   machine, CRC byte step and lowest-set-bit channel match all settle
//   combinationally between the parser state and result registers.
//   The final CRC byte beat registers the result into the output stage.
// Reset:
//   Synchronous rst returns the parser to hunting for the first start byte,
//   clears CRC and counters and empties the output stage.
// Stall:
//   A two-entry output stage (result register plus skid) keeps s_tready
//   high while a result waits; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module srxl2_channel_frame_parser #(
  parameter int MAX_KEPT = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input, tdata: rx_byte[7:0]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // result output, tdata: first_value[15:0], second_value[31:16],
  // captured_count[33:32], zero pad [39:34]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import srxl_pkg::*;

  logic       accept;
  logic [4:0] aux_channel;
  res_push_t  result;
  frame_res_t m_res;

  assign accept  = s_tvalid && s_tready;
  assign m_tdata = {(TDATA_W - 34)'(0), m_res.captured_count,
                    m_res.second_value, m_res.first_value};

  srxl_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .aux_channel (aux_channel)
  );

  srxl_parser #(
    .MAX_KEPT (MAX_KEPT)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .aux_channel (aux_channel),
    .result      (result)
  );

  srxl_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  // Input stalls only when both output entries hold results
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  // A delivered result always carries at least one word
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd0))
    else $error("result beat with zero captured words");

  // A result landing behind a stalled one fills the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (result.push && m_tvalid && !m_tready) |=> !s_tready)
    else $error("result pushed behind stalled beat was not held");

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the SRXL2 channel frame parser
// Feeds serial bytes (framed channel packets, broken packets and line noise)
// into the byte stream with random gaps. It models the parser byte by byte to
// predict the captured channel words of each good frame. Each result beat is
// compared with that prediction, and the aux channel register is reprogrammed
// and read back between and within phases.
// ----------------------------------------------------------------------------
module tb_top;
  import srxl_pkg::*;

  localparam int MAX_KEPT       = 2;
  localparam int IDLE_MAX       = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 400;
  localparam logic [2:0] AUX_ADDR = {REG_AUX_CHANNEL, 2'b00};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte[7:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // first_value[15:0], second_value[31:16],
                          // captured_count[33:32], zero pad [39:34]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  srxl2_channel_frame_parser #(
    .MAX_KEPT (MAX_KEPT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Parser model state
  parse_state_t fp_state;
  logic [15:0]  fp_crc;
  logic [7:0]   fp_chans;
  logic [31:0]  fp_rem_mask;
  logic [31:0]  fp_want_mask;
  logic [15:0]  fp_word;
  int           fp_kept_n;
  logic [15:0]  fp_kept [MAX_KEPT];
  logic [4:0]   aux_sel;

  frame_res_t   captured_words_q [$];

  int error_count;
  int bytes_sent;
  bit tx_idle;
  bit rx_idle;
  bit rx_hold;

  // CRC-16-CCITT, one data bit at a time, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c,
                                                 input logic [7:0]  d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic reset_frame_model;
    aux_sel      = 5'd1;
    fp_state     = ST_START1;
    fp_crc       = '0;
    fp_chans     = '0;
    fp_rem_mask  = '0;
    fp_want_mask = '0;
    fp_word      = '0;
    fp_kept_n    = 0;
    for (int i = 0; i < MAX_KEPT; i++) begin
      fp_kept[i] = '0;
    end
  endtask

  // Advance the parser model by one accepted byte
  task automatic frame_parse_step(input logic [7:0] b);
    logic       crc_on;
    frame_res_t res;
    crc_on = 1'b1;
    case (fp_state)
      ST_START1: begin
        if (b == START1_BYTE) begin
          fp_state = ST_START2;
          fp_crc   = '0;
        end
      end
      ST_START2: fp_state = (b == START2_BYTE) ? ST_LENGTH : ST_START1;
      ST_LENGTH: begin
        fp_chans = (b >= MIN_LENGTH) ? ((b - MIN_LENGTH) >> 1) : 8'd0;
        fp_state = ST_COMMAND;
      end
      ST_COMMAND: begin
        if (b == CMD_CHANNEL) begin
          fp_state    = ST_REPLYID;
          fp_kept_n   = 0;
          fp_rem_mask = '0;
          fp_word     = '0;
        end else begin
          fp_state = ST_START1;
        end
      end
      ST_REPLYID: fp_state = ST_RSSI;
      ST_RSSI:    fp_state = ST_LOSS1;
      ST_LOSS1:   fp_state = ST_LOSS2;
      ST_LOSS2:   fp_state = (fp_chans == 0) ? ST_CRC1 : ST_MASK1;
      ST_MASK1: begin
        fp_rem_mask = {24'd0, b};
        fp_state    = ST_MASK2;
      end
      ST_MASK2: begin
        fp_rem_mask[15:8] = b;
        fp_state          = ST_MASK3;
      end
      ST_MASK3: begin
        fp_rem_mask[23:16] = b;
        fp_state           = ST_MASK4;
      end
      ST_MASK4: begin
        fp_rem_mask[31:24] = b;
        fp_want_mask       = fp_rem_mask & ((32'd1 << aux_sel) | 32'd1);
        fp_state           = ST_PAY1;
      end
      ST_PAY1: begin
        fp_word  = {8'd0, b};
        fp_state = ST_PAY2;
      end
      ST_PAY2: begin
        fp_word[15:8] = b;
        // match the word to the next set mask bit; none left means unmatched
        if (fp_rem_mask != 0) begin
          while (!fp_rem_mask[0]) begin
            fp_rem_mask  = fp_rem_mask >> 1;
            fp_want_mask = fp_want_mask >> 1;
          end
          if (fp_want_mask[0] && fp_kept_n < MAX_KEPT) begin
            fp_kept[fp_kept_n] = fp_word;
            fp_kept_n++;
          end
        end
        fp_rem_mask  = fp_rem_mask >> 1;
        fp_want_mask = fp_want_mask >> 1;
        if (fp_chans > 0) begin
          fp_chans--;
        end
        fp_state = (fp_chans != 0) ? ST_PAY1 : ST_CRC1;
      end
      ST_CRC1: begin
        crc_on   = 1'b0;
        fp_word  = {8'd0, b};
        fp_state = ST_CRC2;
      end
      ST_CRC2: begin
        crc_on  = 1'b0;
        fp_word = {fp_word[7:0], b};
        if (fp_word == fp_crc && fp_kept_n != 0) begin
          res.first_value    = fp_kept[0];
          res.second_value   = (fp_kept_n >= 2) ? fp_kept[1] : 16'd0;
          res.captured_count = 2'(fp_kept_n);
          captured_words_q.push_back(res);
        end
        fp_state = ST_START1;
      end
      default: fp_state = ST_START1;
    endcase
    if (crc_on) begin
      fp_crc = crc_ccitt_step(fp_crc, b);
    end
  endtask

  // Offer one byte after a random gap, wait for the beat, then model it
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    frame_parse_step(b);
    bytes_sent++;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Build a frame, with a correct (or deliberately broken) CRC on channel frames, and send it
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input logic [31:0] mask, input bit bad_crc);
    logic [7:0]  fb [$];
    logic [15:0] crc;
    logic [15:0] w;
    int          nch;
    fb = {};
    fb.push_back(START1_BYTE);
    fb.push_back(START2_BYTE);
    fb.push_back(len);
    fb.push_back(cmd);
    if (cmd == CMD_CHANNEL) begin
      // reply id, RSSI, two frame-loss bytes
      repeat (4) fb.push_back(8'($urandom));
      nch = (len >= MIN_LENGTH) ? (int'(len) - int'(MIN_LENGTH)) / 2 : 0;
      if (nch > 0) begin
        for (int i = 0; i < 4; i++) begin
          fb.push_back(mask[8*i +: 8]);
        end
        for (int i = 0; i < nch; i++) begin
          w = pick_word();
          fb.push_back(w[7:0]);
          fb.push_back(w[15:8]);
        end
      end
      crc = '0;
      foreach (fb[i]) begin
        crc = crc_ccitt_step(crc, fb[i]);
      end
      if (bad_crc) begin
        crc = crc ^ (16'd1 << $urandom_range(0, 15));
      end
      fb.push_back(crc[15:8]);
      fb.push_back(crc[7:0]);
    end
    foreach (fb[i]) begin
      send_byte(fb[i]);
    end
  endtask

  // Stop offering and wait until every predicted result has left the block
  task automatic drain_and_idle;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (captured_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_aux_readback;
    @(negedge clk);
    s_tvalid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= AUX_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {27'd0, aux_sel}) begin
      $error("aux_channel readback: expected %0h, got %0h", {27'd0, aux_sel}, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_aux(input logic [4:0] v);
    drain_and_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AUX_ADDR;
    pwdata  <= {27'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    aux_sel = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_aux_readback();
  endtask

  function automatic logic [7:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 13));
      1:       return 8'($urandom_range(14, 15));
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(16, 32));
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0;
      3:       return (32'd1 << aux_sel) | 32'($urandom_range(0, 1));
      4:       return 32'd1 | (32'd1 << $urandom_range(0, 31));
      default: return 32'd1 | (32'd1 << aux_sel) | ($urandom & 32'h0000_00F0);
    endcase
  endfunction

  // Directed frames: each framing corner once, aux channel at its reset value
  task automatic test_directed;
    // hunting ignores anything but the first start byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START2_BYTE);
    // wrong second start byte
    send_byte(START1_BYTE);
    send_byte(8'h00);
    send_frame(8'd16, CMD_CHANNEL, 32'h1, 1'b0);           // channel 0 only
    send_frame(8'd18, CMD_CHANNEL, 32'h3, 1'b0);           // channel 0 and aux
    send_frame(8'd18, 8'hFF, 32'h3, 1'b0);                 // foreign command
    send_frame(8'd5, CMD_CHANNEL, 32'h0, 1'b0);            // length below minimum
    send_frame(MIN_LENGTH, CMD_CHANNEL, 32'h0, 1'b0);      // no channels
    send_frame(8'd20, CMD_CHANNEL, 32'h1, 1'b0);           // mask runs out
    send_frame(8'd18, CMD_CHANNEL, 32'h3, 1'b1);           // corrupted CRC
    send_frame(8'd18, CMD_CHANNEL, 32'h0000_0C00, 1'b0);   // nothing kept
    send_frame(8'd30, CMD_CHANNEL, 32'hFFFF_FFFF, 1'b0);   // keep limit
    send_frame(8'd255, CMD_CHANNEL, 32'hFFFF_FFFF, 1'b0);  // longest frame
  endtask

  // Aux channel register: reset value, both extremes and a middle value
  task automatic test_aux_channel;
    check_aux_readback();
    write_aux(5'd0);
    send_frame(8'd18, CMD_CHANNEL, 32'h3, 1'b0);
    send_frame(8'd18, CMD_CHANNEL, 32'h2, 1'b0);
    write_aux(5'd31);
    send_frame(8'd18, CMD_CHANNEL, 32'h8000_0001, 1'b0);
    send_frame(8'd16, CMD_CHANNEL, 32'h8000_0000, 1'b0);
    send_frame(8'd80, CMD_CHANNEL, 32'hFFFF_FFFF, 1'b0);
    write_aux(5'($urandom_range(2, 30)));
    repeat (4) send_frame(pick_len(), CMD_CHANNEL, pick_mask(), 1'b0);
    write_aux(5'd1);
  endtask

  // Receiver holds off while short good frames keep coming
  task automatic test_output_stall;
    drain_and_idle();
    tx_idle = 1'b0;
    rx_hold = 1'b1;
    repeat (40) send_frame(8'd16, CMD_CHANNEL, 32'h1, 1'b0);
    tx_idle = 1'b1;
  endtask

  // Sender stops mid-stream until every result is out
  task automatic test_sender_pause;
    repeat (3) send_frame(8'd18, CMD_CHANNEL, 32'h3, 1'b0);
    drain_and_idle();
    repeat (3) send_frame(pick_len(), CMD_CHANNEL, pick_mask(), 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus noise and breakage
  task automatic test_random_stream;
    int          frames;
    int          start_bytes;
    logic [7:0]  cmd;
    start_bytes = bytes_sent;
    frames      = 0;
    while ((bytes_sent - start_bytes < RANDOM_BYTES) && frames < 3000) begin
      if (frames % 5 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (frames % 10 == 9) begin
        write_aux(5'($urandom_range(0, 31)));
      end
      case ($urandom_range(0, 15))
        0: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
        1: begin
          send_byte(START1_BYTE);
          send_byte(8'($urandom));
        end
        default: begin
          cmd = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : CMD_CHANNEL;
          send_frame(pick_len(), cmd, pick_mask(), $urandom_range(0, 7) == 0);
        end
      endcase
      frames++;
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result beat check against the oldest prediction
  always @(posedge clk) begin
    frame_res_t exp_res;
    frame_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = frame_res_t'(m_tdata[33:0]);
      if (captured_words_q.size() == 0) begin
        $error("unexpected result beat: first_value %h second_value %h count %0d",
               got.first_value, got.second_value, got.captured_count);
        error_count++;
      end else begin
        exp_res = captured_words_q.pop_front();
        if (got.first_value !== exp_res.first_value) begin
          $error("first_value: expected %h, got %h", exp_res.first_value, got.first_value);
          error_count++;
        end
        if (got.second_value !== exp_res.second_value) begin
          $error("second_value: expected %h, got %h", exp_res.second_value,
                 got.second_value);
          error_count++;
        end
        if (got.captured_count !== exp_res.captured_count) begin
          $error("captured_count: expected %0d, got %0d", exp_res.captured_count,
                 got.captured_count);
          error_count++;
        end
        if (m_tdata[39:34] !== 6'd0) begin
          $error("tdata pad: expected %h, got %h", 6'd0, m_tdata[39:34]);
          error_count++;
        end
      end
    end
  end

  // Result side readiness: random stalls, one long hold on request
  initial begin
    int rx_gap;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      rx_gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (rx_hold) begin
        rx_gap  = HOLD_CYCLES;
        rx_hold = 1'b0;
      end
      if (rx_gap > 0) begin
        m_tready <= 1'b0;
        repeat (rx_gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Watchdog: cycles in a row with no beat on any port
  always @(posedge clk) begin
    int quiet_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Test sequence
  initial begin
    error_count   = 0;
    bytes_sent    = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rx_hold       = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    reset_frame_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_aux_channel();
    test_output_stall();
    test_sender_pause();
    test_random_stream();

    drain_and_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/srxl_pkg.sv
rtl/srxl_cfg_regs.sv
rtl/srxl_parser.sv
rtl/srxl_out_skid.sv
rtl/srxl2_channel_frame_parser.sv
tb/tb_top.sv
